[rtl/spc_pkg.sv]
// Shared constants and types for the sphere pair collision response block.
// No dependencies; every other file imports this package.
package spc_pkg;

    // Radius register width and the widths that follow from it.
    localparam int RADIUS_BITS = 18;
    localparam int SPAN_BITS   = RADIUS_BITS + 1;   // 2 * radius
    localparam int DIFF_BITS   = SPAN_BITS + 1;     // signed center difference in contact range
    localparam int DMAG_BITS   = SPAN_BITS;         // magnitude of one difference component
    localparam int DD_BITS     = 2 * DMAG_BITS + 2; // squared distance, three terms

    // Split point of the wide velocity-dot magnitude for the product stage.
    localparam int SPLIT_BITS  = 23;

    localparam int AXES        = 3;

    // Outcome of the classification, carried with each pair to the back end.
    typedef struct packed {
        logic hit;
        logic refl0;
        logic refl1;
    } spc_flags_t;

endpackage

[rtl/spc_front.sv]
// Front end: accepts pairs, forms differences and dot products, classifies contact.
// Depends on spc_pkg.
module spc_front
    import spc_pkg::*;
#(
    parameter int WORD_BITS = 24
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [RADIUS_BITS-1:0]          radius,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [4*AXES*WORD_BITS-1:0]     in_data,
    output logic                            ent_valid,
    input  logic                            ent_ready,
    output logic [AXES*WORD_BITS-1:0]       ent_v0,
    output logic [AXES*WORD_BITS-1:0]       ent_v1,
    output logic [AXES*DIFF_BITS-1:0]       ent_d,
    output logic [WORD_BITS+DIFF_BITS+1:0]  ent_v0d,
    output logic [WORD_BITS+DIFF_BITS+1:0]  ent_v1d,
    output logic [DD_BITS-1:0]              ent_dd,
    output spc_flags_t                      ent_flags
);

    localparam int W       = WORD_BITS;
    localparam int DF_BITS = (W + 1 > DIFF_BITS) ? W + 1 : DIFF_BITS;
    localparam int PD_BITS = 2 * DIFF_BITS;
    localparam int PV_BITS = W + DIFF_BITS;
    localparam int PR_BITS = W + 1 + DIFF_BITS;
    localparam int VD_BITS = W + DIFF_BITS + 2;
    localparam int DR_BITS = W + DIFF_BITS + 3;

    logic                      adv;
    logic [2:0]                vld_reg;
    logic [SPAN_BITS-1:0]      span_u;
    logic signed [DF_BITS-1:0] span_s;
    logic [DD_BITS-1:0]        span_sq_reg;

    logic signed [W-1:0]       p0_c [AXES];
    logic signed [W-1:0]       v0_c [AXES];
    logic signed [W-1:0]       p1_c [AXES];
    logic signed [W-1:0]       v1_c [AXES];
    logic signed [DF_BITS-1:0] d_full_c [AXES];
    logic signed [W:0]         rel_c [AXES];
    logic                      near_c;

    logic signed [W-1:0]         s1_v0_reg [AXES];
    logic signed [W-1:0]         s1_v1_reg [AXES];
    logic signed [DIFF_BITS-1:0] s1_d_reg [AXES];
    logic signed [W:0]           s1_rel_reg [AXES];
    logic                        s1_near_reg;

    logic signed [W-1:0]         s2_v0_reg [AXES];
    logic signed [W-1:0]         s2_v1_reg [AXES];
    logic signed [DIFF_BITS-1:0] s2_d_reg [AXES];
    logic signed [PD_BITS-1:0]   s2_sq_reg [AXES];
    logic signed [PV_BITS-1:0]   s2_p0_reg [AXES];
    logic signed [PV_BITS-1:0]   s2_p1_reg [AXES];
    logic signed [PR_BITS-1:0]   s2_pr_reg [AXES];
    logic                        s2_near_reg;

    logic signed [PD_BITS+1:0]   dd_sum_c;

    logic signed [W-1:0]         s3_v0_reg [AXES];
    logic signed [W-1:0]         s3_v1_reg [AXES];
    logic signed [DIFF_BITS-1:0] s3_d_reg [AXES];
    logic [DD_BITS-1:0]          s3_dd_reg;
    logic signed [VD_BITS-1:0]   s3_v0d_reg;
    logic signed [VD_BITS-1:0]   s3_v1d_reg;
    logic signed [DR_BITS-1:0]   s3_dr_reg;
    logic                        s3_near_reg;
    logic                        hit_c;

    // Stall the whole front end while the queue is full.
    assign adv      = ent_ready;
    assign in_ready = adv;

    assign span_u = {radius, 1'b0};
    assign span_s = DF_BITS'(signed'({1'b0, span_u}));

    always_ff @(posedge aclk) begin
        span_sq_reg <= DD_BITS'(span_u) * DD_BITS'(span_u);
    end

    // Unpack fields, form differences, test each axis against the contact span.
    always_comb begin
        near_c = 1'b1;
        for (int i = 0; i < AXES; i++) begin
            p0_c[i]     = signed'(in_data[i*W +: W]);
            v0_c[i]     = signed'(in_data[(AXES+i)*W +: W]);
            p1_c[i]     = signed'(in_data[(2*AXES+i)*W +: W]);
            v1_c[i]     = signed'(in_data[(3*AXES+i)*W +: W]);
            d_full_c[i] = DF_BITS'(p1_c[i]) - DF_BITS'(p0_c[i]);
            rel_c[i]    = (W+1)'(v1_c[i]) - (W+1)'(v0_c[i]);
            if (!((d_full_c[i] < span_s) && (d_full_c[i] > -span_s))) begin
                near_c = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[1:0], in_valid};
        end
    end

    always_comb begin
        dd_sum_c = (PD_BITS+2)'(s2_sq_reg[0]) + (PD_BITS+2)'(s2_sq_reg[1])
                 + (PD_BITS+2)'(s2_sq_reg[2]);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            // stage 1: differences
            for (int i = 0; i < AXES; i++) begin
                s1_v0_reg[i]  <= v0_c[i];
                s1_v1_reg[i]  <= v1_c[i];
                s1_d_reg[i]   <= d_full_c[i][DIFF_BITS-1:0];
                s1_rel_reg[i] <= rel_c[i];
            end
            s1_near_reg <= near_c;
            // stage 2: products
            for (int i = 0; i < AXES; i++) begin
                s2_v0_reg[i] <= s1_v0_reg[i];
                s2_v1_reg[i] <= s1_v1_reg[i];
                s2_d_reg[i]  <= s1_d_reg[i];
                s2_sq_reg[i] <= PD_BITS'(s1_d_reg[i]) * PD_BITS'(s1_d_reg[i]);
                s2_p0_reg[i] <= PV_BITS'(s1_v0_reg[i]) * PV_BITS'(s1_d_reg[i]);
                s2_p1_reg[i] <= PV_BITS'(s1_v1_reg[i]) * PV_BITS'(s1_d_reg[i]);
                s2_pr_reg[i] <= PR_BITS'(s1_rel_reg[i]) * PR_BITS'(s1_d_reg[i]);
            end
            s2_near_reg <= s1_near_reg;
            // stage 3: sums
            for (int i = 0; i < AXES; i++) begin
                s3_v0_reg[i] <= s2_v0_reg[i];
                s3_v1_reg[i] <= s2_v1_reg[i];
                s3_d_reg[i]  <= s2_d_reg[i];
            end
            s3_dd_reg   <= dd_sum_c[DD_BITS-1:0];
            s3_v0d_reg  <= VD_BITS'(s2_p0_reg[0]) + VD_BITS'(s2_p0_reg[1])
                         + VD_BITS'(s2_p0_reg[2]);
            s3_v1d_reg  <= VD_BITS'(s2_p1_reg[0]) + VD_BITS'(s2_p1_reg[1])
                         + VD_BITS'(s2_p1_reg[2]);
            s3_dr_reg   <= DR_BITS'(s2_pr_reg[0]) + DR_BITS'(s2_pr_reg[1])
                         + DR_BITS'(s2_pr_reg[2]);
            s3_near_reg <= s2_near_reg;
        end
    end

    // Contact: overlapping and approaching. Each ball reflects only when it heads in.
    assign hit_c = s3_near_reg && (s3_dd_reg < span_sq_reg) && s3_dr_reg[DR_BITS-1];

    always_comb begin
        ent_flags.hit   = hit_c;
        ent_flags.refl1 = hit_c && s3_v1d_reg[VD_BITS-1];
        ent_flags.refl0 = hit_c && !s3_v0d_reg[VD_BITS-1] && (s3_v0d_reg != '0);
        for (int i = 0; i < AXES; i++) begin
            ent_v0[i*W +: W]                = s3_v0_reg[i];
            ent_v1[i*W +: W]                = s3_v1_reg[i];
            ent_d[i*DIFF_BITS +: DIFF_BITS] = s3_d_reg[i];
        end
    end

    assign ent_valid = vld_reg[2];
    assign ent_dd    = s3_dd_reg;
    assign ent_v0d   = s3_v0d_reg;
    assign ent_v1d   = s3_v1d_reg;

endmodule

[rtl/spc_fifo.sv]
// Short queue between the classifying front end and the response back end.
// Depends on spc_pkg. DEPTH must be a power of two.
module spc_fifo
    import spc_pkg::*;
#(
    parameter int DATA_BITS = 8,
    parameter int DEPTH     = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 wr_valid,
    output logic                 wr_ready,
    input  logic [DATA_BITS-1:0] wr_data,
    output logic                 rd_valid,
    input  logic                 rd_ready,
    output logic [DATA_BITS-1:0] rd_data
);

    localparam int PTR_BITS = $clog2(DEPTH);

    logic [DATA_BITS-1:0] mem_reg [DEPTH];
    logic [PTR_BITS-1:0]  wr_ptr_reg;
    logic [PTR_BITS-1:0]  rd_ptr_reg;
    logic [PTR_BITS:0]    count_reg;
    logic                 push;
    logic                 pop;

    assign wr_ready = (count_reg != (PTR_BITS+1)'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_data  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

[rtl/spc_div.sv]
// Pipelined restoring divider, one quotient bit per stage, saturating quotient.
// Depends on spc_pkg.
module spc_div
    import spc_pkg::*;
#(
    parameter int NUM_BITS = 66,
    parameter int DEN_BITS = 40,
    parameter int QUO_BITS = 25
) (
    input  logic                aclk,
    input  logic                en,
    input  logic [NUM_BITS-1:0] num,
    input  logic [DEN_BITS-1:0] den,
    output logic [QUO_BITS-1:0] quo
);

    localparam int CMP_BITS =
        ((NUM_BITS > DEN_BITS + QUO_BITS) ? NUM_BITS : DEN_BITS + QUO_BITS) + 1;

    logic [NUM_BITS-1:0] rem_reg [QUO_BITS+1];
    logic [DEN_BITS-1:0] den_reg [QUO_BITS+1];
    logic [QUO_BITS-1:0] quo_reg [QUO_BITS+1];
    logic [QUO_BITS:0]   sat_reg;

    // Entry stage: flag quotients that do not fit, so the bit stages can skip them.
    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= num;
            den_reg[0] <= den;
            quo_reg[0] <= '0;
            sat_reg[0] <= (CMP_BITS'(num) >= (CMP_BITS'(den) << QUO_BITS));
        end
    end

    for (genvar k = 1; k <= QUO_BITS; k++) begin : g_step
        logic [CMP_BITS-1:0] cand;
        logic                take;

        assign cand = CMP_BITS'(den_reg[k-1]) << (QUO_BITS - k);
        assign take = !sat_reg[k-1] && (CMP_BITS'(rem_reg[k-1]) >= cand);

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k] <= take ? rem_reg[k-1] - cand[NUM_BITS-1:0] : rem_reg[k-1];
                den_reg[k] <= den_reg[k-1];
                quo_reg[k] <= quo_reg[k-1] | (QUO_BITS'(take) << (QUO_BITS - k));
                sat_reg[k] <= sat_reg[k-1];
            end
        end
    end

    assign quo = sat_reg[QUO_BITS] ? {QUO_BITS{1'b1}} : quo_reg[QUO_BITS];

endmodule

[rtl/spc_back.sv]
// Back end: reflection terms 2*d_i*(v.d)/|d|^2 per lane, subtraction, saturation.
// Depends on spc_pkg and spc_div.
module spc_back
    import spc_pkg::*;
#(
    parameter int WORD_BITS = 24
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            ent_valid,
    output logic                            ent_ready,
    input  logic [AXES*WORD_BITS-1:0]       ent_v0,
    input  logic [AXES*WORD_BITS-1:0]       ent_v1,
    input  logic [AXES*DIFF_BITS-1:0]       ent_d,
    input  logic [WORD_BITS+DIFF_BITS+1:0]  ent_v0d,
    input  logic [WORD_BITS+DIFF_BITS+1:0]  ent_v1d,
    input  logic [DD_BITS-1:0]              ent_dd,
    input  spc_flags_t                      ent_flags,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [2*AXES*WORD_BITS-1:0]     out_vel,
    output logic                            out_collided
);

    localparam int W         = WORD_BITS;
    localparam int VD_BITS   = W + DIFF_BITS + 2;
    localparam int HI_BITS   = VD_BITS - SPLIT_BITS;
    localparam int PL_BITS   = DMAG_BITS + SPLIT_BITS;
    localparam int PH_BITS   = DMAG_BITS + HI_BITS;
    localparam int NUM_BITS  = DMAG_BITS + VD_BITS + 1;
    localparam int QUO_BITS  = W + 1;
    localparam int LANES     = 2 * AXES;
    localparam int SIDE_LEN  = QUO_BITS + 4;
    localparam int FLAG_BITS = $bits(spc_flags_t);
    localparam int SIDE_BITS = LANES * W + LANES + FLAG_BITS;
    localparam longint VMAX_L = (longint'(1) << (W - 1)) - 1;
    localparam logic signed [W+2:0] VMAX = (W+3)'(VMAX_L);
    localparam logic signed [W+2:0] VMIN = -VMAX - 1;

    logic                        adv;
    logic [SIDE_LEN-1:0]         vld_reg;
    logic [SIDE_BITS-1:0]        side_reg [SIDE_LEN];
    logic [SIDE_BITS-1:0]        side_c;
    logic [SIDE_BITS-1:0]        side_o;
    spc_flags_t                  flags_o;
    logic                        out_valid_reg;
    logic [LANES*W-1:0]          out_vel_reg;
    logic                        out_collided_reg;

    logic signed [DIFF_BITS-1:0] d_c [AXES];
    logic [DMAG_BITS-1:0]        md_c [AXES];
    logic signed [VD_BITS-1:0]   vd_c [2];
    logic [VD_BITS-1:0]          mvd_c [2];
    logic [LANES-1:0]            neg_c;

    logic [DMAG_BITS-1:0]        a_md_reg [AXES];
    logic [VD_BITS-1:0]          a_mvd_reg [2];
    logic [DD_BITS-1:0]          a_dd_reg;
    logic [PL_BITS-1:0]          b_pl_reg [LANES];
    logic [PH_BITS-1:0]          b_ph_reg [LANES];
    logic [DD_BITS-1:0]          b_dd_reg;
    logic [NUM_BITS-1:0]         c_num_reg [LANES];
    logic [DD_BITS-1:0]          c_dd_reg;
    logic [QUO_BITS-1:0]         quo_w [LANES];

    logic signed [W-1:0]         v_c [LANES];
    logic signed [QUO_BITS:0]    mag_c [LANES];
    logic signed [QUO_BITS:0]    t_c [LANES];
    logic signed [W+2:0]         nv_c [LANES];
    logic [W-1:0]                res_c [LANES];

    // Advance the whole back end whenever the output register can take a result.
    assign adv       = !out_valid_reg || out_ready;
    assign ent_ready = adv;

    // Magnitudes and signs of the reflection terms.
    always_comb begin
        for (int i = 0; i < AXES; i++) begin
            d_c[i]  = signed'(ent_d[i*DIFF_BITS +: DIFF_BITS]);
            md_c[i] = d_c[i][DIFF_BITS-1] ? DMAG_BITS'(-d_c[i]) : DMAG_BITS'(d_c[i]);
        end
        vd_c[0] = signed'(ent_v0d);
        vd_c[1] = signed'(ent_v1d);
        for (int b = 0; b < 2; b++) begin
            mvd_c[b] = vd_c[b][VD_BITS-1] ? VD_BITS'(-vd_c[b]) : VD_BITS'(vd_c[b]);
            for (int i = 0; i < AXES; i++) begin
                neg_c[b*AXES+i] = d_c[i][DIFF_BITS-1] ^ vd_c[b][VD_BITS-1];
            end
        end
        side_c = {ent_flags, neg_c, ent_v1, ent_v0};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            vld_reg       <= {vld_reg[SIDE_LEN-2:0], ent_valid};
            out_valid_reg <= vld_reg[SIDE_LEN-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            side_reg[0] <= side_c;
            for (int k = 1; k < SIDE_LEN; k++) begin
                side_reg[k] <= side_reg[k-1];
            end
            // magnitudes
            for (int i = 0; i < AXES; i++) begin
                a_md_reg[i] <= md_c[i];
            end
            a_mvd_reg[0] <= mvd_c[0];
            a_mvd_reg[1] <= mvd_c[1];
            a_dd_reg     <= ent_dd;
            // split products
            for (int b = 0; b < 2; b++) begin
                for (int i = 0; i < AXES; i++) begin
                    b_pl_reg[b*AXES+i] <= PL_BITS'(a_md_reg[i])
                                        * PL_BITS'(a_mvd_reg[b][SPLIT_BITS-1:0]);
                    b_ph_reg[b*AXES+i] <= PH_BITS'(a_md_reg[i])
                                        * PH_BITS'(a_mvd_reg[b][VD_BITS-1:SPLIT_BITS]);
                end
            end
            b_dd_reg <= a_dd_reg;
            // numerator 2*|d_i|*|v.d|
            for (int l = 0; l < LANES; l++) begin
                c_num_reg[l] <= (NUM_BITS'(b_ph_reg[l]) << (SPLIT_BITS + 1))
                              + (NUM_BITS'(b_pl_reg[l]) << 1);
            end
            c_dd_reg <= b_dd_reg;
        end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        spc_div #(
            .NUM_BITS (NUM_BITS),
            .DEN_BITS (DD_BITS),
            .QUO_BITS (QUO_BITS)
        ) u_div (
            .aclk (aclk),
            .en   (adv),
            .num  (c_num_reg[l]),
            .den  (c_dd_reg),
            .quo  (quo_w[l])
        );
    end

    // Apply the signed term, hold the velocity of a ball that does not reflect, clamp.
    always_comb begin
        side_o  = side_reg[SIDE_LEN-1];
        flags_o = spc_flags_t'(side_o[SIDE_BITS-1 -: FLAG_BITS]);
        for (int l = 0; l < LANES; l++) begin
            v_c[l]   = signed'(side_o[l*W +: W]);
            mag_c[l] = signed'({1'b0, quo_w[l]});
            t_c[l]   = side_o[LANES*W + l] ? -mag_c[l] : mag_c[l];
            if ((l < AXES) ? flags_o.refl0 : flags_o.refl1) begin
                nv_c[l] = (W+3)'(v_c[l]) - (W+3)'(t_c[l]);
            end else begin
                nv_c[l] = (W+3)'(v_c[l]);
            end
            if (nv_c[l] > VMAX) begin
                res_c[l] = VMAX[W-1:0];
            end else if (nv_c[l] < VMIN) begin
                res_c[l] = VMIN[W-1:0];
            end else begin
                res_c[l] = nv_c[l][W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int l = 0; l < LANES; l++) begin
                out_vel_reg[l*W +: W] <= res_c[l];
            end
            out_collided_reg <= flags_o.hit;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_vel      = out_vel_reg;
    assign out_collided = out_collided_reg;

endmodule

[rtl/sphere_pair_collision_response.sv]
// Sphere pair collision response. One candidate pair of equal balls enters per
// transaction on the s_ channel and one response leaves per transaction on the m_
// channel, in order. The block takes a new pair every clock cycle while the queue
// is not full. Most of the pipeline depth lies in the pipelined restoring dividers
// in the back end, one quotient bit per stage, six in parallel (one per velocity
// component of both balls). A front end computes the center difference, the dot
// products and the contact test; a four-entry queue lets the front end and the
// back end stall independently. The contact radius is written through cfg_wr_en /
// cfg_wr_data and must only change while no pair is in flight.
// Depends on spc_pkg, spc_front, spc_fifo, spc_div and spc_back.
module sphere_pair_collision_response
    import spc_pkg::*;
#(
    parameter int WORD_BITS = 24,
    parameter int FRAC_BITS = 12
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [RADIUS_BITS-1:0] cfg_wr_data,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // first_pos_x/y/z, first_vel_x/y/z, second_pos_x/y/z, second_vel_x/y/z, zero pad
    input  logic [((4*AXES*WORD_BITS+7)/8)*8-1:0] s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // first_new_vel_x/y/z, second_new_vel_x/y/z, zero pad
    output logic [((2*AXES*WORD_BITS+7)/8)*8-1:0] m_tdata,
    // collided
    output logic [0:0]             m_tuser
);

    localparam int W         = WORD_BITS;
    localparam int VD_BITS   = W + DIFF_BITS + 2;
    localparam int OUT_BITS  = ((2*AXES*W + 7) / 8) * 8;
    localparam int ENT_BITS  = 2*AXES*W + AXES*DIFF_BITS + 2*VD_BITS + DD_BITS
                             + $bits(spc_flags_t);
    localparam int Q_DEPTH   = 4;

    logic [RADIUS_BITS-1:0]   radius_reg;

    logic                     f_valid;
    logic                     f_ready;
    logic [AXES*W-1:0]        f_v0;
    logic [AXES*W-1:0]        f_v1;
    logic [AXES*DIFF_BITS-1:0] f_d;
    logic [VD_BITS-1:0]       f_v0d;
    logic [VD_BITS-1:0]       f_v1d;
    logic [DD_BITS-1:0]       f_dd;
    spc_flags_t               f_flags;

    logic                     b_valid;
    logic                     b_ready;
    logic [ENT_BITS-1:0]      q_wr_data;
    logic [ENT_BITS-1:0]      q_rd_data;
    logic [AXES*W-1:0]        b_v0;
    logic [AXES*W-1:0]        b_v1;
    logic [AXES*DIFF_BITS-1:0] b_d;
    logic [VD_BITS-1:0]       b_v0d;
    logic [VD_BITS-1:0]       b_v1d;
    logic [DD_BITS-1:0]       b_dd;
    spc_flags_t               b_flags;

    logic [2*AXES*W-1:0]      out_vel;
    logic                     out_collided;

    // Radius register: 1.0 in fixed point after reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= RADIUS_BITS'(longint'(1) << FRAC_BITS);
        end else if (cfg_wr_en) begin
            radius_reg <= cfg_wr_data;
        end
    end

    spc_front #(
        .WORD_BITS (W)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .radius    (radius_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (s_tdata[4*AXES*W-1:0]),
        .ent_valid (f_valid),
        .ent_ready (f_ready),
        .ent_v0    (f_v0),
        .ent_v1    (f_v1),
        .ent_d     (f_d),
        .ent_v0d   (f_v0d),
        .ent_v1d   (f_v1d),
        .ent_dd    (f_dd),
        .ent_flags (f_flags)
    );

    // Pack the classified pair into one queue entry.
    assign q_wr_data = {f_flags, f_dd, f_v1d, f_v0d, f_d, f_v1, f_v0};

    spc_fifo #(
        .DATA_BITS (ENT_BITS),
        .DEPTH     (Q_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_data  (q_wr_data),
        .rd_valid (b_valid),
        .rd_ready (b_ready),
        .rd_data  (q_rd_data)
    );

    assign {b_flags, b_dd, b_v1d, b_v0d, b_d, b_v1, b_v0} = q_rd_data;

    spc_back #(
        .WORD_BITS (W)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ent_valid    (b_valid),
        .ent_ready    (b_ready),
        .ent_v0       (b_v0),
        .ent_v1       (b_v1),
        .ent_d        (b_d),
        .ent_v0d      (b_v0d),
        .ent_v1d      (b_v1d),
        .ent_dd       (b_dd),
        .ent_flags    (b_flags),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_vel      (out_vel),
        .out_collided (out_collided)
    );

    // Zero-fill the result word to whole bytes.
    assign m_tdata = OUT_BITS'(out_vel);
    assign m_tuser = out_collided;

endmodule
